### design/fbpa_pkg.sv
package fbpa_pkg;

	localparam int DEF_MAX_CELLS = 256;
	localparam int ADDR_W        = 32;
	localparam int CELL_W        = 17;
	localparam int INIT_W        = 9;
	localparam int COUNT_W       = 9;

	localparam logic [CELL_W-1:0] RST_CELL_BYTES = CELL_W'(8);

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_QUERY   = 2'd2
	} cmd_e;

	typedef enum logic [1:0] {
		CFG_POOL_BASE     = 2'd0,
		CFG_CELL_BYTES    = 2'd1,
		CFG_INITIAL_CELLS = 2'd2
	} cfg_idx_e;

	typedef struct packed {
		logic [1:0]        command;
		logic [ADDR_W-1:0] block_address;
	} item_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  result_address;
		logic               success;
		logic [COUNT_W-1:0] free_cells;
		logic [COUNT_W-1:0] total_cells;
	} result_t;

	// free list requests and status
	typedef struct packed {
		logic init;
		logic push;
		logic pop;
	} fl_req_t;

	typedef struct packed {
		logic has_entry;
		logic full;
	} fl_status_t;

	// outcome of one command before the free-list read data is merged in
	typedef struct packed {
		logic               use_fifo;
		logic [ADDR_W-1:0]  address;
		logic               success;
		logic [COUNT_W-1:0] free_cells;
		logic [COUNT_W-1:0] total_cells;
	} outcome_t;

endpackage

### design/fbpa_free_list.sv
module fbpa_free_list
	import fbpa_pkg::*;
#(
	parameter int MAX_CELLS = DEF_MAX_CELLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fl_req_t           req,
	input  logic [ADDR_W-1:0] push_data,
	output fl_status_t        status,
	output logic [ADDR_W-1:0] rd_data
);

	localparam int IDX_W = $clog2(MAX_CELLS);
	localparam int CNT_W = $clog2(MAX_CELLS + 1);

	logic [ADDR_W-1:0] mem [MAX_CELLS];
	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  tail_q;
	logic [CNT_W-1:0]  entries_q;
	logic [ADDR_W-1:0] rd_q;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
		logic [IDX_W:0] inc;
		inc = {1'b0, idx} + 1'b1;
		return (32'(inc) >= 32'(MAX_CELLS)) ? '0 : inc[IDX_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			entries_q <= '0;
		end else if (req.init) begin
			head_q    <= '0;
			tail_q    <= '0;
			entries_q <= '0;
		end else begin
			if (req.push) begin
				tail_q    <= next_idx(tail_q);
				entries_q <= entries_q + 1'b1;
			end
			if (req.pop) begin
				head_q    <= next_idx(head_q);
				entries_q <= entries_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.push && !req.init) begin
			mem[tail_q] <= push_data;
		end
		if (req.pop) begin
			rd_q <= mem[head_q];
		end
	end

	assign rd_data          = rd_q;
	assign status.has_entry = (entries_q != '0);
	assign status.full      = (32'(entries_q) >= 32'(MAX_CELLS));

	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.push && req.pop))
		else $error("free list push and pop in the same cycle");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		req.pop |-> entries_q != '0)
		else $error("free list pop while empty");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		req.push |-> 32'(entries_q) < 32'(MAX_CELLS))
		else $error("free list push while full");

	a_init_clears: assert property (@(posedge clk) disable iff (!arst_n)
		req.init |=> entries_q == '0)
		else $error("free list not emptied by reinitialisation");

endmodule

### design/fbpa_pool_state.sv
module fbpa_pool_state
	import fbpa_pkg::*;
#(
	parameter int MAX_CELLS = DEF_MAX_CELLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_fire,
	input  logic [1:0]        cfg_index,
	input  logic [ADDR_W-1:0] cfg_data,
	input  logic              item_fire,
	input  item_t             item,
	input  fl_status_t        fl_status,
	output fl_req_t           fl_req,
	output outcome_t          outcome
);

	localparam int CNT_W  = $clog2(MAX_CELLS + 1);
	localparam int SPAN_W = CNT_W + CELL_W;

	logic [ADDR_W-1:0] base_q;
	logic [CELL_W-1:0] cell_q;
	logic [INIT_W-1:0] init_q;
	logic [CNT_W-1:0]  cap_q;
	logic [ADDR_W-1:0] carve_q;
	logic [CNT_W-1:0]  avail_q;

	logic [ADDR_W-1:0] base_n;
	logic [CELL_W-1:0] cell_n;
	logic [INIT_W-1:0] init_n;
	logic [CNT_W-1:0]  cap_n;
	logic [SPAN_W-1:0] carve_span;
	logic [ADDR_W-1:0] carve_init;
	logic              reinit;

	logic [ADDR_W-1:0] carve_n;
	logic [CNT_W-1:0]  avail_n;
	logic              do_pop;
	logic              do_push;
	logic              do_carve;
	logic              ok;

	// new register values for a configuration write
	always_comb begin
		base_n = base_q;
		cell_n = cell_q;
		init_n = init_q;
		reinit = 1'b0;
		if (cfg_fire) begin
			unique case (cfg_index)
				CFG_POOL_BASE: begin
					base_n = cfg_data;
					reinit = 1'b1;
				end
				CFG_CELL_BYTES: begin
					cell_n = cfg_data[CELL_W-1:0];
					reinit = 1'b1;
				end
				CFG_INITIAL_CELLS: begin
					init_n = cfg_data[INIT_W-1:0];
					reinit = 1'b1;
				end
				default: reinit = 1'b0;
			endcase
		end
		cap_n      = (32'(init_n) > 32'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : CNT_W'(init_n);
		carve_span = SPAN_W'(cap_n) * SPAN_W'(cell_n);
		carve_init = base_n + ADDR_W'(carve_span);
	end

	// command decode
	always_comb begin
		do_pop   = 1'b0;
		do_push  = 1'b0;
		do_carve = 1'b0;
		ok       = 1'b0;
		if (item_fire) begin
			unique case (item.command)
				CMD_ALLOC: begin
					if (avail_q != '0) begin
						ok       = 1'b1;
						do_pop   = fl_status.has_entry;
						do_carve = !fl_status.has_entry;
					end
				end
				CMD_RELEASE: begin
					if (avail_q < cap_q && !fl_status.full) begin
						ok      = 1'b1;
						do_push = 1'b1;
					end
				end
				CMD_QUERY: ok = 1'b1;
				default:   ok = 1'b0;
			endcase
		end
		carve_n = do_carve ? carve_q - ADDR_W'(cell_q) : carve_q;
		avail_n = avail_q;
		if (do_pop || do_carve) begin
			avail_n = avail_q - 1'b1;
		end else if (do_push) begin
			avail_n = avail_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			cell_q  <= RST_CELL_BYTES;
			init_q  <= '0;
			cap_q   <= '0;
			carve_q <= '0;
			avail_q <= '0;
		end else if (reinit) begin
			base_q  <= base_n;
			cell_q  <= cell_n;
			init_q  <= init_n;
			cap_q   <= cap_n;
			carve_q <= carve_init;
			avail_q <= cap_n;
		end else begin
			carve_q <= carve_n;
			avail_q <= avail_n;
		end
	end

	assign fl_req.init = reinit;
	assign fl_req.push = do_push;
	assign fl_req.pop  = do_pop;

	assign outcome.use_fifo    = do_pop;
	assign outcome.address     = do_carve ? carve_n : '0;
	assign outcome.success     = ok;
	assign outcome.free_cells  = COUNT_W'(32'(avail_n));
	assign outcome.total_cells = COUNT_W'(32'(cap_q));

	a_avail_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		avail_q <= cap_q)
		else $error("free count above capacity");

	a_carve_step: assert property (@(posedge clk) disable iff (!arst_n)
		do_carve && !reinit |=> carve_q == $past(carve_q) - ADDR_W'($past(cell_q)))
		else $error("carve address did not step down by one cell");

	a_fail_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire && !ok && !reinit |=> avail_q == $past(avail_q))
		else $error("refused command changed the free count");

endmodule

### design/fixed_block_pool_allocator_core.sv
// Fixed-size block pool allocator.
//
// Commands enter on item when start is high and busy is low: allocate hands
// out the oldest released block or carves a fresh cell downward from the top
// of the pool area; release returns a block to the free list; query reports
// the counts. Every command yields exactly one result on result, marked by
// done for one cycle; the receiver cannot stall, so results are never held.
//
// done is registered and high in the cycle after the accepting edge. Throughput
// is one command per cycle while busy is low; the free-list memory reads the head
// entry at the accepting edge and the pool counters update at the same edge.
//
// Configuration registers are written over cfg_valid/cfg_ready (always ready);
// each write to index 0..2 reinitialises the pool: empty free list, full
// free count, carve address back at the top of the area. Write them only while idle.
//
// After reset busy is high for one cycle; the pool holds the reset register
// values, and the free-list memory is not cleared (no clearing pass).
module fixed_block_pool_allocator_core
	import fbpa_pkg::*;
#(
	parameter int MAX_CELLS = DEF_MAX_CELLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  item_t             item,
	output logic              done,
	output result_t           result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [ADDR_W-1:0] cfg_data
);

	logic              busy_q;
	logic              item_fire;
	logic              cfg_fire;
	fl_req_t           fl_req;
	fl_status_t        fl_status;
	logic [ADDR_W-1:0] fl_rd;
	outcome_t          outcome;
	outcome_t          outcome_s1;
	logic              done_s1;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign busy      = busy_q;
	assign item_fire = start && !busy_q;

	fbpa_pool_state #(
		.MAX_CELLS(MAX_CELLS)
	) u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_fire (cfg_fire),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.item_fire(item_fire),
		.item     (item),
		.fl_status(fl_status),
		.fl_req   (fl_req),
		.outcome  (outcome)
	);

	fbpa_free_list #(
		.MAX_CELLS(MAX_CELLS)
	) u_free_list (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (fl_req),
		.push_data(item.block_address),
		.status   (fl_status),
		.rd_data  (fl_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			done_s1 <= 1'b0;
		end else begin
			busy_q  <= 1'b0;
			done_s1 <= item_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			outcome_s1 <= outcome;
		end
	end

	// merge the registered free-list read for allocations served from the list
	always_comb begin
		result.result_address = outcome_s1.use_fifo ? fl_rd : outcome_s1.address;
		result.success        = outcome_s1.success;
		result.free_cells     = outcome_s1.free_cells;
		result.total_cells    = outcome_s1.total_cells;
	end

	assign done = done_s1;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire |=> done)
		else $error("accepted transaction produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!item_fire |=> !done)
		else $error("result without an accepted transaction");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		done && !outcome_s1.success |-> result.result_address == '0)
		else $error("failed command returned a non-zero address");

endmodule
